// File: src/iso8601_to_epoch_seconds_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ISO8601 to epoch seconds block
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ISO8601_TO_EPOCH_SECONDS_ASSERT_SVH
`define ISO8601_TO_EPOCH_SECONDS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define I2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define I2E_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/iso2epoch_pkg.sv
// ----------------------------------------------------------------------------
// ISO8601 to epoch seconds package
// Character codes, field positions, widths and offset parsing helpers.
// ----------------------------------------------------------------------------
package iso2epoch_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned EPOCH_W    = 39;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned TAIL_DEPTH = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [4:0] POS_YM_SEP = 5'd4;
  localparam logic [4:0] POS_MD_SEP = 5'd7;
  localparam logic [4:0] POS_DT_SEP = 5'd10;
  localparam logic [4:0] POS_HM_SEP = 5'd13;
  localparam logic [4:0] POS_MS_SEP = 5'd16;
  localparam logic [4:0] PREFIX_LEN = 5'd19;
  localparam logic [4:0] POS_CAP    = 5'd20;

  typedef logic [TAIL_DEPTH-1:0][CHAR_W-1:0] tail_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] hh;
    logic [6:0] mm;
  } offset_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    return 7'({3'b000, hi[3:0]} * 7'd10 + {3'b000, lo[3:0]});
  endfunction

  function automatic offset_t offset_parse(input tail_t t, input logic [2:0] n);
    offset_t r;
    r = '0;
    if (n >= 3'd5 && is_digit(t[0]) && is_digit(t[1]) && t[2] == CH_COLON &&
        is_digit(t[3]) && is_digit(t[4])) begin
      r.valid = 1'b1;
      r.hh    = two_digits(t[0], t[1]);
      r.mm    = two_digits(t[3], t[4]);
    end else if (n >= 3'd4 && is_digit(t[0]) && is_digit(t[1]) &&
                 is_digit(t[2]) && is_digit(t[3])) begin
      r.valid = 1'b1;
      r.hh    = two_digits(t[0], t[1]);
      r.mm    = two_digits(t[2], t[3]);
    end
    return r;
  endfunction

endpackage

// File: src/iso8601_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// ISO8601 timestamp to Unix epoch seconds
// Takes one character per beat in s_axis_tdata; tlast marks the final one.
// Every character but the last is taken while the block is idle. After the
// last one, s_axis_tready drops while a shared multiply-accumulate unit runs
// a fixed 20-step sequence, each step a multiply state then an accumulate
// state, to turn the date and time fields and the zone offset into seconds.
// The result beat appears and the block is ready again together once the
// sequence ends, or later if the previous result has not been taken.
// A failed parse still runs the full sequence and returns seconds 0.
// ----------------------------------------------------------------------------
module iso8601_to_epoch_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic        m_axis_tuser    // parse_ok
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [4:0] SQ_ERA_EST   = 5'd0;
  localparam logic [4:0] SQ_YP_LOAD   = 5'd1;
  localparam logic [4:0] SQ_YOE_SUB   = 5'd2;
  localparam logic [4:0] SQ_C100_EST  = 5'd3;
  localparam logic [4:0] SQ_MP_MUL    = 5'd4;
  localparam logic [4:0] SQ_MP_ADD    = 5'd5;
  localparam logic [4:0] SQ_DBM_EST   = 5'd6;
  localparam logic [4:0] SQ_ERA_DAYS  = 5'd7;
  localparam logic [4:0] SQ_YOE_DAYS  = 5'd8;
  localparam logic [4:0] SQ_LEAP4     = 5'd9;
  localparam logic [4:0] SQ_LEAP100   = 5'd10;
  localparam logic [4:0] SQ_DBM_ADD   = 5'd11;
  localparam logic [4:0] SQ_DAY_ADD   = 5'd12;
  localparam logic [4:0] SQ_EPOCH_ADJ = 5'd13;
  localparam logic [4:0] SQ_DAY_SECS  = 5'd14;
  localparam logic [4:0] SQ_HOUR_SECS = 5'd15;
  localparam logic [4:0] SQ_MIN_SECS  = 5'd16;
  localparam logic [4:0] SQ_SEC_ADD   = 5'd17;
  localparam logic [4:0] SQ_OFF_HOURS = 5'd18;
  localparam logic [4:0] SQ_OFF_MINS  = 5'd19;

  localparam logic signed [21:0] K_ONE      = 22'sd1;
  localparam logic signed [21:0] K_TWO      = 22'sd2;
  localparam logic signed [21:0] K_NEG_ONE  = -22'sd1;
  localparam logic signed [21:0] K_INV400   = 22'sd5243;
  localparam logic signed [21:0] K_NEG_400  = -22'sd400;
  localparam logic signed [21:0] K_INV100   = 22'sd41;
  localparam logic signed [21:0] K_153      = 22'sd153;
  localparam logic signed [21:0] K_INV5     = 22'sd52429;
  localparam logic signed [21:0] K_ERA_DAYS = 22'sd146097;
  localparam logic signed [21:0] K_365      = 22'sd365;
  localparam logic signed [21:0] K_EPOCH    = -22'sd719469;
  localparam logic signed [21:0] K_DAY_SECS = 22'sd86400;
  localparam logic signed [21:0] K_3600     = 22'sd3600;
  localparam logic signed [21:0] K_NEG_3600 = -22'sd3600;
  localparam logic signed [21:0] K_60       = 22'sd60;
  localparam logic signed [21:0] K_NEG_60   = -22'sd60;

  logic [1:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;

  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  min_q, min_d;
  logic [6:0]  sec_q, sec_d;
  logic        fail_q, fail_d;
  logic        zulu_q, zulu_d;
  logic        plus_q, plus_d;
  logic        minus_q, minus_d;
  logic [2:0]  pcnt_q, pcnt_d;
  logic [2:0]  mcnt_q, mcnt_d;

  iso2epoch_pkg::tail_t ptail_q, ptail_d;
  iso2epoch_pkg::tail_t mtail_q, mtail_d;

  logic signed [39:0] acc_q;
  logic signed [39:0] prod_q;
  logic               clr_q;
  logic signed [5:0]  era_q;
  logic [8:0]         yoe_q;
  logic [1:0]         q100_q;
  logic [11:0]        dbm_q;

  logic [39:0] out_data_q;
  logic        out_ok_q;
  logic        out_valid_q, out_valid_d;

  logic               in_fire;
  logic               fin_fire;
  logic [7:0]         c;
  logic               le2;
  logic signed [14:0] yp;
  logic [6:0]         mp;
  logic               off_apply;
  iso2epoch_pkg::offset_t off;
  logic               ok;
  logic               clr;
  logic signed [24:0] a_op;
  logic signed [21:0] b_op;
  logic signed [46:0] prod_full;

  assign c        = s_axis_tdata;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  assign le2 = (month_q <= 7'd2);
  assign yp  = $signed({1'b0, year_q}) - (le2 ? 15'sd1 : 15'sd0);
  assign mp  = le2 ? month_q + 7'd9 : month_q - 7'd3;

  assign off_apply = !zulu_q && (plus_q || minus_q);
  assign off = plus_q ? iso2epoch_pkg::offset_parse(ptail_q, pcnt_q)
                      : iso2epoch_pkg::offset_parse(mtail_q, mcnt_q);
  assign ok  = !fail_q && (pos_q >= iso2epoch_pkg::PREFIX_LEN) &&
               (!off_apply || off.valid);

  // Character parsing
  always_comb begin
    pos_d   = pos_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    fail_d  = fail_q;
    zulu_d  = zulu_q;
    plus_d  = plus_q;
    minus_d = minus_q;
    pcnt_d  = pcnt_q;
    mcnt_d  = mcnt_q;
    ptail_d = ptail_q;
    mtail_d = mtail_q;
    if (in_fire) begin
      if (pos_q < iso2epoch_pkg::PREFIX_LEN) begin
        unique case (pos_q) inside
          iso2epoch_pkg::POS_YM_SEP, iso2epoch_pkg::POS_MD_SEP: begin
            if (c != iso2epoch_pkg::CH_DASH) fail_d = 1'b1;
          end
          iso2epoch_pkg::POS_DT_SEP: begin
            if (c != iso2epoch_pkg::CH_T) fail_d = 1'b1;
          end
          iso2epoch_pkg::POS_HM_SEP, iso2epoch_pkg::POS_MS_SEP: begin
            if (c != iso2epoch_pkg::CH_COLON) fail_d = 1'b1;
          end
          default: begin
            if (!iso2epoch_pkg::is_digit(c)) begin
              fail_d = 1'b1;
            end else if (pos_q < iso2epoch_pkg::POS_YM_SEP) begin
              year_d = 14'(year_q * 14'd10 + {10'd0, c[3:0]});
            end else if (pos_q < iso2epoch_pkg::POS_MD_SEP) begin
              month_d = 7'(month_q * 7'd10 + {3'd0, c[3:0]});
            end else if (pos_q < iso2epoch_pkg::POS_DT_SEP) begin
              day_d = 7'(day_q * 7'd10 + {3'd0, c[3:0]});
            end else if (pos_q < iso2epoch_pkg::POS_HM_SEP) begin
              hour_d = 7'(hour_q * 7'd10 + {3'd0, c[3:0]});
            end else if (pos_q < iso2epoch_pkg::POS_MS_SEP) begin
              min_d = 7'(min_q * 7'd10 + {3'd0, c[3:0]});
            end else begin
              sec_d = 7'(sec_q * 7'd10 + {3'd0, c[3:0]});
            end
          end
        endcase
      end else begin
        if (c == iso2epoch_pkg::CH_Z) zulu_d = 1'b1;
        if (plus_q && pcnt_q < 3'(iso2epoch_pkg::TAIL_DEPTH)) begin
          ptail_d[pcnt_q] = c;
          pcnt_d = pcnt_q + 3'd1;
        end
        if (minus_q && mcnt_q < 3'(iso2epoch_pkg::TAIL_DEPTH)) begin
          mtail_d[mcnt_q] = c;
          mcnt_d = mcnt_q + 3'd1;
        end
        if (c == iso2epoch_pkg::CH_PLUS) plus_d = 1'b1;
        if (c == iso2epoch_pkg::CH_DASH) minus_d = 1'b1;
      end
      if (pos_q < iso2epoch_pkg::POS_CAP) pos_d = pos_q + 5'd1;
    end
    if (fin_fire) begin
      pos_d   = '0;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      fail_d  = 1'b0;
      zulu_d  = 1'b0;
      plus_d  = 1'b0;
      minus_d = 1'b0;
      pcnt_d  = '0;
      mcnt_d  = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = ST_MUL;
          step_d  = SQ_ERA_EST;
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (step_q == SQ_OFF_MINS) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
          step_d  = step_q + 5'd1;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiply-accumulate unit
  always_comb begin
    clr  = 1'b0;
    a_op = '0;
    b_op = '0;
    unique case (step_q)
      SQ_ERA_EST:   begin clr = 1'b1; a_op = 25'(yp); b_op = K_INV400; end
      SQ_YP_LOAD:   begin clr = 1'b1; a_op = 25'(yp); b_op = K_ONE; end
      SQ_YOE_SUB:   begin a_op = 25'(era_q); b_op = K_NEG_400; end
      SQ_C100_EST:  begin clr = 1'b1; a_op = $signed({16'd0, acc_q[8:0]}); b_op = K_INV100; end
      SQ_MP_MUL:    begin clr = 1'b1; a_op = $signed({18'd0, mp}); b_op = K_153; end
      SQ_MP_ADD:    begin a_op = 25'sd1; b_op = K_TWO; end
      SQ_DBM_EST:   begin clr = 1'b1; a_op = $signed({10'd0, acc_q[14:0]}); b_op = K_INV5; end
      SQ_ERA_DAYS:  begin clr = 1'b1; a_op = 25'(era_q); b_op = K_ERA_DAYS; end
      SQ_YOE_DAYS:  begin a_op = $signed({16'd0, yoe_q}); b_op = K_365; end
      SQ_LEAP4:     begin a_op = $signed({18'd0, yoe_q[8:2]}); b_op = K_ONE; end
      SQ_LEAP100:   begin a_op = $signed({23'd0, q100_q}); b_op = K_NEG_ONE; end
      SQ_DBM_ADD:   begin a_op = $signed({13'd0, dbm_q}); b_op = K_ONE; end
      SQ_DAY_ADD:   begin a_op = $signed({18'd0, day_q}); b_op = K_ONE; end
      SQ_EPOCH_ADJ: begin a_op = 25'sd1; b_op = K_EPOCH; end
      SQ_DAY_SECS:  begin clr = 1'b1; a_op = 25'($signed(acc_q[23:0])); b_op = K_DAY_SECS; end
      SQ_HOUR_SECS: begin a_op = $signed({18'd0, hour_q}); b_op = K_3600; end
      SQ_MIN_SECS:  begin a_op = $signed({18'd0, min_q}); b_op = K_60; end
      SQ_SEC_ADD:   begin a_op = $signed({18'd0, sec_q}); b_op = K_ONE; end
      SQ_OFF_HOURS: begin
        a_op = $signed({18'd0, off.hh});
        b_op = !off_apply ? '0 : (plus_q ? K_NEG_3600 : K_3600);
      end
      SQ_OFF_MINS: begin
        a_op = $signed({18'd0, off.mm});
        b_op = !off_apply ? '0 : (plus_q ? K_NEG_60 : K_60);
      end
      default: begin
        clr  = 1'b0;
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_full = a_op * b_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      fail_q      <= 1'b0;
      zulu_q      <= 1'b0;
      plus_q      <= 1'b0;
      minus_q     <= 1'b0;
      pcnt_q      <= '0;
      mcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      fail_q      <= fail_d;
      zulu_q      <= zulu_d;
      plus_q      <= plus_d;
      minus_q     <= minus_d;
      pcnt_q      <= pcnt_d;
      mcnt_q      <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptail_q <= ptail_d;
    mtail_q <= mtail_d;
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[39:0];
      clr_q  <= clr;
      case (step_q)
        SQ_YP_LOAD:  era_q  <= yp[14] ? -6'sd1 : $signed(acc_q[26:21]);
        SQ_C100_EST: yoe_q  <= acc_q[8:0];
        SQ_MP_MUL:   q100_q <= acc_q[13:12];
        SQ_ERA_DAYS: dbm_q  <= acc_q[29:18];
        default: ;
      endcase
    end
    if (state_q == ST_ADD) begin
      acc_q <= clr_q ? prod_q : acc_q + prod_q;
    end
    if (fin_fire) begin
      out_data_q <= ok ? {1'b0, acc_q[38:0]} : '0;
      out_ok_q   <= ok;
    end
  end

endmodule

// File: src/iso2epoch_chk.sv
// ----------------------------------------------------------------------------
// ISO8601 to epoch seconds port checker
// Watches the stream ports of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
`include "iso8601_to_epoch_seconds_assert.svh"

module iso2epoch_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic [iso2epoch_pkg::CHAR_W-1:0]       s_axis_tdata,
  input logic                                   s_axis_tlast,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [iso2epoch_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                                   m_axis_tuser
);

  `I2E_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
  `I2E_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
  `I2E_ASSERT(a_fail_zero, !(m_axis_tvalid && !m_axis_tuser) || (m_axis_tdata == '0), "failed parse with nonzero seconds")
  `I2E_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "ready after final character")

endmodule

bind iso8601_to_epoch_seconds iso2epoch_chk u_iso2epoch_chk (.*);
